### design/tlat_pkg.sv
// Package: constants, types and the decay arithmetic of the load-average tracker.
package tlat_pkg;

   localparam int unsigned INTERVAL     = 500;
   localparam int unsigned TICK_RATE    = 100;
   localparam int unsigned MAX_RUNNABLE = 1023;

   localparam int unsigned COUNT_W    = 48;
   localparam int unsigned RUNNABLE_W = 10;
   localparam int unsigned AVG_W      = 21;
   localparam int unsigned SECONDS_W  = 42;
   localparam int unsigned EPOCH_W    = 32;
   localparam int unsigned FRAC_BITS  = 11;
   localparam int unsigned FACTOR_W   = 12;
   localparam int unsigned NUM_AVG    = 3;

   localparam int unsigned SUB_W = (TICK_RATE > 1) ? $clog2(TICK_RATE) : 1;
   localparam int unsigned PROD_W = AVG_W + FACTOR_W;

   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 208;

   localparam logic [FACTOR_W-1:0] ONE_FIXED = FACTOR_W'(2048);

   typedef logic [FACTOR_W-1:0] factor_type;

   // One-, five- and fifteen-minute decay factors out of 2048
   localparam factor_type DECAY_FACTOR [NUM_AVG] = '{
      FACTOR_W'(1884), FACTOR_W'(2014), FACTOR_W'(2037)
   };

   typedef struct packed {
      logic [REQ_DATA_W-RUNNABLE_W-2:0] pad;
      logic                             cpu_idle;
      logic [RUNNABLE_W-1:0]            runnable_count;
   } req_data_type;

   typedef struct packed {
      logic [5:0]           pad;
      logic [SECONDS_W-1:0] realtime_seconds;
      logic                 averages_updated;
      logic [AVG_W-1:0]     load_fifteen;
      logic [AVG_W-1:0]     load_five;
      logic [AVG_W-1:0]     load_one;
      logic [COUNT_W-1:0]   idle_ticks;
      logic [COUNT_W-1:0]   uptime_ticks;
   } rsp_data_type;

   // avg' = (avg*e + active*2048*(2048-e)) >> 11, saturated to the average width.
   // The active term has zero low bits, so it adds after the shift.
   function automatic logic [AVG_W-1:0] decay(input logic [AVG_W-1:0] avg,
                                              input logic [RUNNABLE_W-1:0] active,
                                              input factor_type factor);
      logic [PROD_W-1:0]  prod;
      logic [AVG_W:0]     acc;
      logic [FACTOR_W-1:0] comp;
      begin
         prod = PROD_W'(avg) * PROD_W'(factor);
         comp = ONE_FIXED - factor;
         acc  = (AVG_W+1)'(prod >> FRAC_BITS) + (AVG_W+1)'(active) * (AVG_W+1)'(comp);
         decay = acc[AVG_W] ? {AVG_W{1'b1}} : acc[AVG_W-1:0];
      end
   endfunction

endpackage

### design/tick_load_average_tracker_unit.sv
// Top level: scheduler tick counter with idle accounting and three load averages.
//
// Each req item is one scheduler tick (runnable thread count and idle flag); each tick
// returns exactly one rsp item with the uptime and idle tick counters, the one-, five-
// and fifteen-minute load averages (scaled by 2048), a flag set on ticks that crossed
// an update interval, and wall-clock seconds (boot epoch plus whole seconds of uptime).
// The averages decay once every INTERVAL ticks. The path is an input register, one
// pass of update logic, and the result register; an item's result is registered in the
// result register when the item advances out of the input register, and the rate is
// one item per cycle while rsp_tready stays high.
// Uptime seconds are counted alongside the ticks with a sub-second counter, so no
// divider is needed. Write csr_wr_data only while no item is in flight.
module tick_load_average_tracker_unit
   import tlat_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata, low bit up: runnable_count[9:0], cpu_idle[10], zero pad[15:11]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // rsp_tdata, low bit up: uptime_ticks[47:0], idle_ticks[95:48], load_one[116:96],
   // load_five[137:117], load_fifteen[158:138], averages_updated[159],
   // realtime_seconds[201:160], zero pad[207:202]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_wr_en,
   input  logic [EPOCH_W-1:0]    csr_wr_data
);

   req_data_type req_data;

   // input register
   logic                  in_valid_ff;
   logic [RUNNABLE_W-1:0] in_count_ff;
   logic                  in_idle_ff;

   // tick state
   logic [COUNT_W-1:0]   uptime_ff, uptime_in;
   logic [COUNT_W-1:0]   idle_ff, idle_in;
   logic [COUNT_W-1:0]   next_update_ff, next_update_in;
   logic [SUB_W-1:0]     sub_ff, sub_in;
   logic [SECONDS_W-1:0] sec_ff, sec_in;
   logic [AVG_W-1:0]     avg_ff [NUM_AVG];
   logic [AVG_W-1:0]     avg_in [NUM_AVG];
   logic [EPOCH_W-1:0]   epoch_ff;

   // result register
   logic         out_valid_ff;
   rsp_data_type out_data_ff, out_data_in;

   logic                  advance;
   logic                  do_update;
   logic [RUNNABLE_W-1:0] active;

   assign req_data   = req_data_type'(req_tdata);
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // Hold an item in the input register until the result register can take its result
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_count_ff <= req_data.runnable_count;
         in_idle_ff  <= req_data.cpu_idle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff <= '0;
      end else if (csr_wr_en) begin
         epoch_ff <= csr_wr_data;
      end
   end

   // Clamp the runnable count to the supported maximum
   assign active = (32'(in_count_ff) > MAX_RUNNABLE) ? RUNNABLE_W'(MAX_RUNNABLE)
                                                      : in_count_ff;

   always_comb begin
      uptime_in = uptime_ff + COUNT_W'(1);
      idle_in   = in_idle_ff ? idle_ff + COUNT_W'(1) : idle_ff;

      // Whole seconds follow the tick counter; both restart when it wraps
      if (uptime_in == '0) begin
         sub_in = '0;
         sec_in = '0;
      end else if (sub_ff == SUB_W'(TICK_RATE - 1)) begin
         sub_in = '0;
         sec_in = sec_ff + SECONDS_W'(1);
      end else begin
         sub_in = sub_ff + SUB_W'(1);
         sec_in = sec_ff;
      end

      do_update      = (uptime_in == next_update_ff);
      next_update_in = do_update ? next_update_ff + COUNT_W'(INTERVAL) : next_update_ff;

      for (int i = 0; i < NUM_AVG; i++) begin
         avg_in[i] = do_update ? decay(avg_ff[i], active, DECAY_FACTOR[i]) : avg_ff[i];
      end

      out_data_in                  = '0;
      out_data_in.uptime_ticks     = uptime_in;
      out_data_in.idle_ticks       = idle_in;
      out_data_in.load_one         = avg_in[0];
      out_data_in.load_five        = avg_in[1];
      out_data_in.load_fifteen     = avg_in[2];
      out_data_in.averages_updated = do_update;
      out_data_in.realtime_seconds = SECONDS_W'(epoch_ff) + sec_in;
   end

   // Advance the tick state once per item that moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         uptime_ff      <= '0;
         idle_ff        <= '0;
         next_update_ff <= COUNT_W'(INTERVAL);
         sub_ff         <= '0;
         sec_ff         <= '0;
         for (int i = 0; i < NUM_AVG; i++) begin
            avg_ff[i] <= '0;
         end
      end else if (advance) begin
         uptime_ff      <= uptime_in;
         idle_ff        <= idle_in;
         next_update_ff <= next_update_in;
         sub_ff         <= sub_in;
         sec_ff         <= sec_in;
         for (int i = 0; i < NUM_AVG; i++) begin
            avg_ff[i] <= avg_in[i];
         end
      end
   end

   // Result register: drop the item once taken, load the next one as it advances
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

### sim/tick_report_checker.sv
// Checker: predicts each tick report of the load-average tracker and compares it field by field.
`timescale 1ns / 100ps
module tick_report_checker
   import tlat_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   // runnable_count[9:0], cpu_idle[10], zero pad[15:11]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // uptime_ticks[47:0], idle_ticks[95:48], load_one[116:96], load_five[137:117],
   // load_fifteen[158:138], averages_updated[159], realtime_seconds[201:160], pad[207:202]
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_wr_en,
   input  logic [EPOCH_W-1:0]    csr_wr_data,
   output int unsigned           mismatch_count,
   output int unsigned           pending_reports,
   output int unsigned           reports_checked,
   output int unsigned           averages_seen
);

   localparam int unsigned PRINT_CAP   = 40;
   localparam logic [63:0] SCALE       = 64'd2048;
   localparam logic [63:0] AVG_CEILING = 64'h1F_FFFF;
   localparam logic [63:0] DECAY_E [NUM_AVG] = '{64'd1884, 64'd2014, 64'd2037};

   logic [COUNT_W-1:0] uptime_model;
   logic [COUNT_W-1:0] idle_model;
   logic [COUNT_W-1:0] next_update_model;
   logic [AVG_W-1:0]   load_model [NUM_AVG];
   logic [EPOCH_W-1:0] epoch_model;
   rsp_data_type       expected_reports [$];

   initial begin
      mismatch_count  = 0;
      pending_reports = 0;
      reports_checked = 0;
      averages_seen   = 0;
   end

   function automatic logic [AVG_W-1:0] fold_average(input logic [AVG_W-1:0] avg,
                                                    input logic [RUNNABLE_W-1:0] active,
                                                    input logic [63:0] e);
      logic [63:0] sum;
      sum = (64'(avg) * e + 64'(active) * SCALE * (SCALE - e)) >> FRAC_BITS;
      return (sum > AVG_CEILING) ? AVG_CEILING[AVG_W-1:0] : sum[AVG_W-1:0];
   endfunction

   // Advance the tick state by one tick and return the report it should produce.
   function automatic rsp_data_type account_tick(input req_data_type tick);
      rsp_data_type          rep;
      logic [RUNNABLE_W-1:0] active;
      logic [63:0]           seconds;
      int                    k;
      rep    = '0;
      active = (tick.runnable_count > MAX_RUNNABLE) ? RUNNABLE_W'(MAX_RUNNABLE)
                                                    : tick.runnable_count;
      uptime_model = uptime_model + 1'b1;
      if (tick.cpu_idle) begin
         idle_model = idle_model + 1'b1;
      end
      if (uptime_model == next_update_model) begin
         for (k = 0; k < NUM_AVG; k++) begin
            load_model[k] = fold_average(load_model[k], active, DECAY_E[k]);
         end
         next_update_model    = next_update_model + COUNT_W'(INTERVAL);
         rep.averages_updated = 1'b1;
      end
      seconds              = 64'(epoch_model) + 64'(uptime_model) / 64'(TICK_RATE);
      rep.uptime_ticks     = uptime_model;
      rep.idle_ticks       = idle_model;
      rep.load_one         = load_model[0];
      rep.load_five        = load_model[1];
      rep.load_fifteen     = load_model[2];
      rep.realtime_seconds = seconds[SECONDS_W-1:0];
      return rep;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                  input logic [63:0] want_v);
      if (mismatch_count < PRINT_CAP) begin
         $display("%0t: mismatch on %s after tick %0d: got %0h, expected %0h",
                  $time, what, reports_checked, got_v, want_v);
      end
      mismatch_count++;
   endtask

   task automatic check_field(input string what, input logic [63:0] got_v,
                              input logic [63:0] want_v);
      if (got_v !== want_v) begin
         report_mismatch(what, got_v, want_v);
      end
   endtask

   task automatic check_report(input rsp_data_type got);
      rsp_data_type want;
      if (expected_reports.size() == 0) begin
         report_mismatch("report with no tick outstanding", 64'(got.uptime_ticks), '0);
      end else begin
         want = expected_reports.pop_front();
         check_field("uptime_ticks", 64'(got.uptime_ticks), 64'(want.uptime_ticks));
         check_field("idle_ticks", 64'(got.idle_ticks), 64'(want.idle_ticks));
         check_field("load_one", 64'(got.load_one), 64'(want.load_one));
         check_field("load_five", 64'(got.load_five), 64'(want.load_five));
         check_field("load_fifteen", 64'(got.load_fifteen), 64'(want.load_fifteen));
         check_field("averages_updated", 64'(got.averages_updated),
                     64'(want.averages_updated));
         check_field("realtime_seconds", 64'(got.realtime_seconds),
                     64'(want.realtime_seconds));
         check_field("pad", 64'(got.pad), 64'(want.pad));
         if (want.averages_updated) begin
            averages_seen++;
         end
      end
      reports_checked++;
   endtask

   // Epoch write first, then the outgoing report, then the incoming tick.
   always @(posedge clock) begin
      if (reset) begin
         uptime_model      = '0;
         idle_model        = '0;
         next_update_model = COUNT_W'(INTERVAL);
         load_model        = '{default: '0};
         epoch_model       = '0;
         expected_reports.delete();
      end else begin
         if (csr_wr_en) begin
            epoch_model = csr_wr_data;
         end
         if (rsp_tvalid && rsp_tready) begin
            check_report(rsp_data_type'(rsp_tdata));
         end
         if (req_tvalid && req_tready) begin
            expected_reports.push_back(account_tick(req_data_type'(req_tdata)));
         end
      end
      pending_reports = expected_reports.size();
   end

endmodule

### sim/tick_load_average_tracker_unit_tb.sv
// Testbench top: drives scheduler ticks and boot epoch writes into the load-average tracker.
`timescale 1ns / 100ps
module tick_load_average_tracker_unit_tb;
   import tlat_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // runnable_count[9:0], cpu_idle[10], zero pad[15:11]
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // uptime_ticks[47:0], idle_ticks[95:48], load_one[116:96], load_five[137:117],
   // load_fifteen[158:138], averages_updated[159], realtime_seconds[201:160], pad[207:202]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en;
   logic [EPOCH_W-1:0]    csr_wr_data;

   // Percentage of cycles in which each side holds off
   int unsigned sender_idle_pct;
   int unsigned receiver_idle_pct;
   int unsigned ticks_sent;
   int unsigned epoch_writes;

   int unsigned mismatch_count;
   int unsigned pending_reports;
   int unsigned reports_checked;
   int unsigned averages_seen;

   tick_load_average_tracker_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   tick_report_checker report_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .mismatch_count  (mismatch_count),
      .pending_reports (pending_reports),
      .reports_checked (reports_checked),
      .averages_seen   (averages_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: stall at random according to the current idling mix, one decision per edge.
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // Present one tick, idling beforehand at random, and hold it until it is taken.
   // Returns at the edge that accepted the item.
   task automatic send_tick(input logic [RUNNABLE_W-1:0] runnable, input logic idle);
      req_data_type tick;
      tick                = '0;
      tick.runnable_count = runnable;
      tick.cpu_idle       = idle;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= tick;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      ticks_sent++;
   endtask

   // Drop valid and wait until every outstanding report has come back.
   task automatic drain_reports();
      req_tvalid <= 1'b0;
      do begin
         @(negedge clock);
      end while (pending_reports != 0);
      @(posedge clock);
   endtask

   // Write the boot epoch; only ever called with nothing in flight.
   task automatic write_epoch(input logic [EPOCH_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      epoch_writes++;
   endtask

   // Random ticks: lean on the extremes now and then, otherwise spread over the full range.
   task automatic run_random_ticks(input int unsigned count);
      logic [RUNNABLE_W-1:0] runnable;
      int unsigned           n;
      for (n = 0; n < count; n++) begin
         case ($urandom_range(7))
            0:       runnable = '0;
            1:       runnable = RUNNABLE_W'(MAX_RUNNABLE);
            default: runnable = RUNNABLE_W'($urandom_range(MAX_RUNNABLE));
         endcase
         send_tick(runnable, 1'($urandom_range(1)));
      end
   endtask

   initial begin
      int b;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      sender_idle_pct   = 34;
      receiver_idle_pct = 64;
      ticks_sent        = 0;
      epoch_writes      = 0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed ticks with the largest epoch: field extremes, each runnable bit alone,
      // alternating patterns and both idle states.
      write_epoch({EPOCH_W{1'b1}});
      send_tick('0, 1'b0);
      send_tick(RUNNABLE_W'(MAX_RUNNABLE), 1'b1);
      send_tick(RUNNABLE_W'(MAX_RUNNABLE), 1'b0);
      send_tick('0, 1'b1);
      for (b = 0; b < RUNNABLE_W; b++) begin
         send_tick(RUNNABLE_W'(1) << b, 1'(b));
      end
      send_tick(RUNNABLE_W'('h155), 1'b1);
      send_tick(RUNNABLE_W'('h2AA), 1'b0);
      drain_reports();

      // Sender idles lightly, receiver stalls heavily.
      write_epoch('0);
      run_random_ticks(180);
      drain_reports();

      // Swap the pressure: sender idles heavily, receiver mostly ready.
      sender_idle_pct   = 64;
      receiver_idle_pct = 34;
      write_epoch(EPOCH_W'($urandom));
      run_random_ticks(180);
      drain_reports();

      // Back to back with no idling on either side; the first average update lands here.
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      write_epoch(EPOCH_W'(1));
      run_random_ticks(180);
      drain_reports();

      // Allow for any stray report beyond the input and result registers.
      repeat (8) @(negedge clock);

      $display("Covered %0d ticks over %0d boot epoch settings and three idling mixes;",
               ticks_sent, epoch_writes);
      $display("checked %0d reports, %0d of them carrying an average update.",
               reports_checked, averages_seen);
      if (mismatch_count == 0) begin
         $display("** tick_load_average_tracker_unit: PASSED **");
      end else begin
         $display("** tick_load_average_tracker_unit: FAILED **");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("** tick_load_average_tracker_unit: FAILED **");
      $finish;
   end

endmodule
